// File: rtl/lfg_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the gamma table for the LED fade engine.
// Depends on nothing; used by led_fade_gamma_engine and the testbench.
package lfg_pkg;

    // Channel count and the index width it needs.
    localparam int CHANNELS = 12;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // Field widths.
    localparam int OPCODE_W = 1;
    localparam int CHAN_W   = 6;
    localparam int TGT_W    = 16;
    localparam int TIME_W   = 32;
    localparam int LVL_W    = 12;
    localparam int PWM_W    = 16;
    localparam int PWM_SHIFT = PWM_W - LVL_W;

    localparam int MAX_LEVEL = (1 << LVL_W) - 1;
    localparam int ROM_DEPTH = 1 << LVL_W;

    // Product of a level difference and an elapsed time.
    localparam int PROD_W = TIME_W + LVL_W;
    localparam int CNT_W  = $clog2(LVL_W);

    // Input tdata layout, lowest bit first: channel, target_level, duration_ms, now_ms.
    localparam int S_CH_LO   = 0;
    localparam int S_TGT_LO  = S_CH_LO + CHAN_W;
    localparam int S_DUR_LO  = S_TGT_LO + TGT_W;
    localparam int S_NOW_LO  = S_DUR_LO + TIME_W;
    localparam int S_USED_W  = S_NOW_LO + TIME_W;
    localparam int S_TDATA_W = ((S_USED_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first: out_channel, pwm_value.
    localparam int M_CH_LO   = 0;
    localparam int M_PWM_LO  = M_CH_LO + CHAN_W;
    localparam int M_USED_W  = M_PWM_LO + PWM_W;
    localparam int M_TDATA_W = ((M_USED_W + 7) / 8) * 8;

    // Opcodes carried in tuser.
    localparam logic [OPCODE_W-1:0] OP_FADE    = 1'b0;
    localparam logic [OPCODE_W-1:0] OP_REFRESH = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_ELAP,
        S_CALC,
        S_MUL,
        S_DIV,
        S_FIN,
        S_UPD,
        S_EMIT
    } t_state;

    typedef logic [LVL_W-1:0] t_gamma_rom [0:ROM_DEPTH-1];

    // gamma(i) = floor(4095 * (i/4095)^2.2): the largest y with
    // y^5 * 4095^6 <= i^11, found bit by bit from the top.
    function automatic t_gamma_rom f_build_gamma();
        t_gamma_rom       rom;
        logic [131:0]     scale;
        logic [131:0]     pw;
        logic [131:0]     cand;
        logic [LVL_W-1:0] y;
        logic [LVL_W-1:0] trial;
        int               i;
        int               k;
        int               b;
        scale = 132'd1;
        for (k = 0; k < 6; k++) begin
            scale = scale * 132'(MAX_LEVEL);
        end
        for (i = 0; i < ROM_DEPTH; i++) begin
            pw = 132'd1;
            for (k = 0; k < 11; k++) begin
                pw = pw * 132'(i);
            end
            y = '0;
            for (b = LVL_W - 1; b >= 0; b--) begin
                trial    = y;
                trial[b] = 1'b1;
                cand     = scale;
                for (k = 0; k < 5; k++) begin
                    cand = cand * 132'(trial);
                end
                if (cand <= pw) begin
                    y = trial;
                end
            end
            rom[i] = y;
        end
        return rom;
    endfunction

    localparam t_gamma_rom GAMMA_ROM = f_build_gamma();

endpackage

// File: rtl/led_fade_gamma_engine.sv
`timescale 1ns / 1ps
// LED fade engine: per-channel linear fades, refreshed to PWM values through a
// 4096-entry gamma 2.2 ROM. Depends on lfg_pkg.
//
// A fade command holds the input while it passes S_ELAP, S_CALC and S_UPD if the channel
// is idle or done, else also S_MUL (a shift-add multiply), S_DIV (a restoring divide) and
// S_FIN. A refresh walks every channel through the same states plus S_EMIT, which waits
// until the output register can be loaded; each result held by the receiver adds its wait.
// One item is worked on at a time.
// Reset (synchronous, active low) clears all channel state and the output valid, and returns the sequencer to idle.
module led_fade_gamma_engine (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // tdata: channel[5:0], target_level[21:6], duration_ms[53:22], now_ms[85:54], zeros
    input  logic [lfg_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode (0 = fade command, 1 = refresh)
    input  logic [lfg_pkg::OPCODE_W-1:0]  s_axis_tuser,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // tdata: out_channel[5:0], pwm_value[21:6], zeros
    output logic [lfg_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic                          m_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready
);

    // ---------------------------------------------------------------------
    // Per-channel fade state, read and written at the channel under work.
    // ---------------------------------------------------------------------
    logic [lfg_pkg::LVL_W-1:0]  r_level      [lfg_pkg::CHANNELS];
    logic                       r_active     [lfg_pkg::CHANNELS];
    logic [lfg_pkg::LVL_W-1:0]  r_start_lvl  [lfg_pkg::CHANNELS];
    logic [lfg_pkg::LVL_W-1:0]  r_tgt_lvl    [lfg_pkg::CHANNELS];
    logic [lfg_pkg::TIME_W-1:0] r_start_time [lfg_pkg::CHANNELS];
    logic [lfg_pkg::TIME_W-1:0] r_len        [lfg_pkg::CHANNELS];

    // Sequencer and captured item.
    lfg_pkg::t_state              r_state;
    lfg_pkg::t_state              n_state;
    logic [lfg_pkg::OPCODE_W-1:0] r_op;
    logic [lfg_pkg::CH_W-1:0]     r_ch;
    logic [lfg_pkg::LVL_W-1:0]    r_tgt;
    logic [lfg_pkg::TIME_W-1:0]   r_dur;
    logic [lfg_pkg::TIME_W-1:0]   r_now;

    // Interpolation datapath.
    logic [lfg_pkg::TIME_W-1:0]   r_elap;
    logic [lfg_pkg::PROD_W-1:0]   r_prod;
    logic [lfg_pkg::CNT_W-1:0]    r_cnt;
    logic                         r_neg;
    logic                         r_fin;
    logic [lfg_pkg::LVL_W-1:0]    r_cur;
    logic [lfg_pkg::LVL_W-1:0]    r_gamma;

    // Output register.
    logic                         r_ovalid;
    logic [lfg_pkg::CHAN_W-1:0]   r_ochan;
    logic [lfg_pkg::PWM_W-1:0]    r_opwm;
    logic                         r_olast;

    // Decoded control.
    logic                         w_s_fire;
    logic                         w_in_range;
    logic                         w_step_last;
    logic                         w_ch_last;
    logic                         w_out_load;
    logic                         w_upd;

    // Input fields.
    logic [lfg_pkg::CHAN_W-1:0]   w_in_ch;
    logic [lfg_pkg::TGT_W-1:0]    w_in_tgt;
    logic [lfg_pkg::LVL_W-1:0]    w_in_tgt_clamp;

    // Channel read port and arithmetic.
    logic                         w_rd_active;
    logic [lfg_pkg::LVL_W-1:0]    w_rd_start;
    logic [lfg_pkg::LVL_W-1:0]    w_rd_tgt;
    logic [lfg_pkg::TIME_W-1:0]   w_rd_len;
    logic                         w_diff_neg;
    logic [lfg_pkg::LVL_W-1:0]    w_diff;
    logic [lfg_pkg::TIME_W:0]     w_mul_sum;
    logic [lfg_pkg::TIME_W:0]     w_div_trial;
    logic                         w_div_ge;
    logic [lfg_pkg::TIME_W:0]     w_div_rem;
    logic [lfg_pkg::LVL_W-1:0]    w_quo;

    assign w_in_ch  = s_axis_tdata[lfg_pkg::S_CH_LO +: lfg_pkg::CHAN_W];
    assign w_in_tgt = s_axis_tdata[lfg_pkg::S_TGT_LO +: lfg_pkg::TGT_W];
    // Clamp the target to the top level.
    assign w_in_tgt_clamp = (w_in_tgt > lfg_pkg::TGT_W'(lfg_pkg::MAX_LEVEL))
                          ? lfg_pkg::LVL_W'(lfg_pkg::MAX_LEVEL)
                          : w_in_tgt[lfg_pkg::LVL_W-1:0];
    assign w_in_range = (int'(w_in_ch) < lfg_pkg::CHANNELS);

    assign w_rd_active = r_active[r_ch];
    assign w_rd_start  = r_start_lvl[r_ch];
    assign w_rd_tgt    = r_tgt_lvl[r_ch];
    assign w_rd_len    = r_len[r_ch];

    assign w_diff_neg = (w_rd_tgt < w_rd_start);
    assign w_diff     = w_diff_neg ? (w_rd_start - w_rd_tgt) : (w_rd_tgt - w_rd_start);

    // Shift-add multiply: one multiplier bit of the difference per cycle,
    // the difference sitting in the low bits of the product register.
    assign w_mul_sum = {1'b0, r_prod[lfg_pkg::PROD_W-1:lfg_pkg::LVL_W]}
                     + (r_prod[0] ? {1'b0, r_elap} : '0);

    // Restoring divide: the upper part starts below the length since the
    // quotient is below the level difference; one quotient bit per cycle.
    assign w_div_trial = {r_prod[lfg_pkg::PROD_W-1:lfg_pkg::LVL_W], r_prod[lfg_pkg::LVL_W-1]};
    assign w_div_ge    = (w_div_trial >= {1'b0, w_rd_len});
    assign w_div_rem   = w_div_ge ? (w_div_trial - {1'b0, w_rd_len}) : w_div_trial;
    assign w_quo       = r_prod[lfg_pkg::LVL_W-1:0];

    // ---------------------------------------------------------------------
    // Next state.
    // ---------------------------------------------------------------------
    always_comb begin
        n_state = r_state;
        case (r_state)
            lfg_pkg::S_IDLE: begin
                if (w_s_fire) begin
                    if (s_axis_tuser == lfg_pkg::OP_FADE && !w_in_range) begin
                        n_state = lfg_pkg::S_IDLE;
                    end else begin
                        n_state = lfg_pkg::S_ELAP;
                    end
                end
            end
            lfg_pkg::S_ELAP: begin
                n_state = lfg_pkg::S_CALC;
            end
            lfg_pkg::S_CALC: begin
                if (!w_rd_active || r_elap >= w_rd_len) begin
                    n_state = lfg_pkg::S_UPD;
                end else begin
                    n_state = lfg_pkg::S_MUL;
                end
            end
            lfg_pkg::S_MUL: begin
                if (w_step_last) begin
                    n_state = lfg_pkg::S_DIV;
                end
            end
            lfg_pkg::S_DIV: begin
                if (w_step_last) begin
                    n_state = lfg_pkg::S_FIN;
                end
            end
            lfg_pkg::S_FIN: begin
                n_state = lfg_pkg::S_UPD;
            end
            lfg_pkg::S_UPD: begin
                n_state = (r_op == lfg_pkg::OP_FADE) ? lfg_pkg::S_IDLE : lfg_pkg::S_EMIT;
            end
            lfg_pkg::S_EMIT: begin
                if (w_out_load) begin
                    n_state = w_ch_last ? lfg_pkg::S_IDLE : lfg_pkg::S_ELAP;
                end
            end
            default: begin
                n_state = lfg_pkg::S_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------------
    // Control outputs of the sequencer.
    // ---------------------------------------------------------------------
    always_comb begin
        s_axis_tready = 1'b0;
        w_out_load    = 1'b0;
        w_upd         = 1'b0;
        case (r_state)
            lfg_pkg::S_IDLE: begin
                s_axis_tready = 1'b1;
            end
            lfg_pkg::S_UPD: begin
                w_upd = 1'b1;
            end
            lfg_pkg::S_EMIT: begin
                // Load when the output register is empty or draining now.
                w_out_load = !r_ovalid || m_axis_tready;
            end
            default: begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    assign w_s_fire    = s_axis_tvalid && s_axis_tready;
    assign w_step_last = (r_cnt == lfg_pkg::CNT_W'(lfg_pkg::LVL_W - 1));
    assign w_ch_last   = (r_ch == lfg_pkg::CH_W'(lfg_pkg::CHANNELS - 1));

    // ---------------------------------------------------------------------
    // Sequencer state and output handshake.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= lfg_pkg::S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_out_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------------
    // Datapath.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        case (r_state)
            lfg_pkg::S_IDLE: begin
                if (w_s_fire) begin
                    r_op  <= s_axis_tuser;
                    // A refresh walks every channel from the first.
                    r_ch  <= (s_axis_tuser == lfg_pkg::OP_FADE)
                           ? w_in_ch[lfg_pkg::CH_W-1:0] : '0;
                    r_tgt <= w_in_tgt_clamp;
                    r_dur <= s_axis_tdata[lfg_pkg::S_DUR_LO +: lfg_pkg::TIME_W];
                    r_now <= s_axis_tdata[lfg_pkg::S_NOW_LO +: lfg_pkg::TIME_W];
                end
            end
            lfg_pkg::S_ELAP: begin
                // Elapsed time wraps modulo 2^32.
                r_elap <= r_now - r_start_time[r_ch];
            end
            lfg_pkg::S_CALC: begin
                r_fin <= 1'b0;
                r_cnt <= '0;
                r_neg <= w_diff_neg;
                r_prod <= {{lfg_pkg::TIME_W{1'b0}}, w_diff};
                if (!w_rd_active) begin
                    r_cur <= r_level[r_ch];
                end else if (r_elap >= w_rd_len) begin
                    r_cur <= w_rd_tgt;
                    r_fin <= 1'b1;
                end
            end
            lfg_pkg::S_MUL: begin
                r_prod <= {w_mul_sum, r_prod[lfg_pkg::LVL_W-1:1]};
                r_cnt  <= w_step_last ? '0 : r_cnt + 1'b1;
            end
            lfg_pkg::S_DIV: begin
                r_prod <= {w_div_rem[lfg_pkg::TIME_W-1:0],
                           r_prod[lfg_pkg::LVL_W-2:0], w_div_ge};
                r_cnt  <= r_cnt + 1'b1;
            end
            lfg_pkg::S_FIN: begin
                // Stays between start and target, so no clamp is needed.
                r_cur <= r_neg ? (w_rd_start - w_quo) : (w_rd_start + w_quo);
            end
            lfg_pkg::S_EMIT: begin
                if (w_out_load) begin
                    r_ochan <= lfg_pkg::CHAN_W'(r_ch);
                    r_opwm  <= {r_gamma, {lfg_pkg::PWM_SHIFT{1'b0}}};
                    r_olast <= w_ch_last;
                    r_ch    <= r_ch + 1'b1;
                end
            end
            default: begin
                r_cnt <= r_cnt;
            end
        endcase
    end

    // Gamma ROM with registered read; the address holds from update to emit.
    always_ff @(posedge i_clk) begin
        r_gamma <= lfg_pkg::GAMMA_ROM[r_cur];
    end

    // ---------------------------------------------------------------------
    // Channel state update.
    // ---------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < lfg_pkg::CHANNELS; c++) begin
                r_level[c]      <= '0;
                r_active[c]     <= 1'b0;
                r_start_lvl[c]  <= '0;
                r_tgt_lvl[c]    <= '0;
                r_start_time[c] <= '0;
                r_len[c]        <= '0;
            end
        end else if (w_upd) begin
            if (r_op == lfg_pkg::OP_FADE) begin
                // Restart from the current level; zero duration jumps at once.
                r_level[r_ch]      <= (r_dur == '0) ? r_tgt : r_cur;
                r_active[r_ch]     <= (r_dur != '0);
                r_start_lvl[r_ch]  <= r_cur;
                r_tgt_lvl[r_ch]    <= r_tgt;
                r_start_time[r_ch] <= r_now;
                r_len[r_ch]        <= r_dur;
            end else begin
                r_level[r_ch] <= r_cur;
                if (r_fin) begin
                    r_active[r_ch] <= 1'b0;
                end
            end
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {{(lfg_pkg::M_TDATA_W - lfg_pkg::M_USED_W){1'b0}}, r_opwm, r_ochan};

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench for led_fade_gamma_engine: directed fade cases, then random traffic.
// Depends on lfg_pkg and led_fade_gamma_engine; builds its own gamma table and level tracker.
module testbench;

    // One PWM result as the engine should emit it.
    typedef struct packed {
        logic [lfg_pkg::CHAN_W-1:0] ch;
        logic [lfg_pkg::PWM_W-1:0]  pwm;
        logic                       last;
    } t_pwm_result;

    // Receiver back-pressure patterns.
    typedef enum logic [1:0] {
        RX_OPEN,
        RX_COIN,
        RX_SPARSE,
        RX_HOLD
    } t_rx_mode;

    logic                           i_clk    = 1'b0;
    logic                           i_rst_n  = 1'b0;
    logic [lfg_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [lfg_pkg::OPCODE_W-1:0]   s_tuser  = lfg_pkg::OP_FADE;
    logic                           s_valid  = 1'b0;
    logic                           s_ready;
    logic [lfg_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                           m_last;
    logic                           m_valid;
    logic                           m_ready  = 1'b0;

    // Tracked channel state, mirrored from the engine's behavior.
    logic [lfg_pkg::LVL_W-1:0]  gamma_lut [0:lfg_pkg::ROM_DEPTH-1];
    logic [lfg_pkg::LVL_W-1:0]  chan_level [lfg_pkg::CHANNELS];
    logic                       chan_fading [lfg_pkg::CHANNELS];
    logic [lfg_pkg::LVL_W-1:0]  fade_from [lfg_pkg::CHANNELS];
    logic [lfg_pkg::LVL_W-1:0]  fade_to [lfg_pkg::CHANNELS];
    logic [lfg_pkg::TIME_W-1:0] fade_t0 [lfg_pkg::CHANNELS];
    logic [lfg_pkg::TIME_W-1:0] fade_len [lfg_pkg::CHANNELS];

    t_pwm_result                pwm_expected_q [$];
    int                         fail_count  = 0;
    int                         burst_left  = 0;
    logic [lfg_pkg::TIME_W-1:0] wall_ms     = '0;
    t_rx_mode                   rx_mode     = RX_OPEN;
    int                         rx_left     = 0;

    led_fade_gamma_engine dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tdata  (s_tdata),
        .s_axis_tuser  (s_tuser),
        .s_axis_tvalid (s_valid),
        .s_axis_tready (s_ready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_last),
        .m_axis_tvalid (m_valid),
        .m_axis_tready (m_ready)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Interpolated level of one channel at time now; fades past their length hold the target.
    function automatic logic [lfg_pkg::LVL_W-1:0] level_at(int ch,
                                                            logic [lfg_pkg::TIME_W-1:0] now);
        logic [lfg_pkg::TIME_W-1:0] elapsed;
        logic [lfg_pkg::LVL_W-1:0]  span;
        logic [63:0]                mag;
        int                         r;
        if (!chan_fading[ch]) begin
            return chan_level[ch];
        end
        elapsed = now - fade_t0[ch];
        if (elapsed >= fade_len[ch]) begin
            return fade_to[ch];
        end
        // Divide the magnitude so the quotient truncates toward zero in both directions.
        if (fade_to[ch] >= fade_from[ch]) begin
            span = fade_to[ch] - fade_from[ch];
            mag  = {52'd0, span} * {32'd0, elapsed} / {32'd0, fade_len[ch]};
            r    = int'(fade_from[ch]) + int'(mag);
        end else begin
            span = fade_from[ch] - fade_to[ch];
            mag  = {52'd0, span} * {32'd0, elapsed} / {32'd0, fade_len[ch]};
            r    = int'(fade_from[ch]) - int'(mag);
        end
        if (r < 0) begin
            r = 0;
        end
        if (r > lfg_pkg::MAX_LEVEL) begin
            r = lfg_pkg::MAX_LEVEL;
        end
        return lfg_pkg::LVL_W'(r);
    endfunction

    // Apply one accepted item to the tracked state and queue the PWM results it causes.
    task automatic track_command(input logic [lfg_pkg::OPCODE_W-1:0] op,
                                 input logic [lfg_pkg::CHAN_W-1:0] ch,
                                 input logic [lfg_pkg::TGT_W-1:0] tgt,
                                 input logic [lfg_pkg::TIME_W-1:0] dur,
                                 input logic [lfg_pkg::TIME_W-1:0] now);
        logic [lfg_pkg::LVL_W-1:0] clamped;
        t_pwm_result               res;
        int                        c;
        if (op == lfg_pkg::OP_FADE) begin
            // Drop commands for channels the engine does not have.
            if (int'(ch) >= lfg_pkg::CHANNELS) begin
                return;
            end
            clamped         = (tgt > lfg_pkg::TGT_W'(lfg_pkg::MAX_LEVEL))
                            ? lfg_pkg::LVL_W'(lfg_pkg::MAX_LEVEL) : tgt[lfg_pkg::LVL_W-1:0];
            chan_level[ch]  = level_at(int'(ch), now);
            chan_fading[ch] = 1'b1;
            fade_from[ch]   = chan_level[ch];
            fade_to[ch]     = clamped;
            fade_t0[ch]     = now;
            fade_len[ch]    = dur;
            // Zero duration: jump straight to the target.
            if (dur == '0) begin
                chan_level[ch]  = clamped;
                chan_fading[ch] = 1'b0;
            end
            return;
        end
        for (c = 0; c < lfg_pkg::CHANNELS; c++) begin
            if (chan_fading[c]) begin
                if (now - fade_t0[c] >= fade_len[c]) begin
                    chan_level[c]  = fade_to[c];
                    chan_fading[c] = 1'b0;
                end else begin
                    chan_level[c] = level_at(c, now);
                end
            end
        end
        for (c = 0; c < lfg_pkg::CHANNELS; c++) begin
            res.ch   = lfg_pkg::CHAN_W'(c);
            res.pwm  = lfg_pkg::PWM_W'(gamma_lut[chan_level[c]]) << lfg_pkg::PWM_SHIFT;
            res.last = (c == lfg_pkg::CHANNELS - 1);
            pwm_expected_q.push_back(res);
        end
    endtask

    // Present one item, hold it until the engine takes it, then update the tracked state.
    task automatic send_item(input logic [lfg_pkg::OPCODE_W-1:0] op,
                             input logic [lfg_pkg::CHAN_W-1:0] ch,
                             input logic [lfg_pkg::TGT_W-1:0] tgt,
                             input logic [lfg_pkg::TIME_W-1:0] dur,
                             input logic [lfg_pkg::TIME_W-1:0] now);
        logic [lfg_pkg::S_TDATA_W-1:0] word;
        int                            gap;
        // Start a new burst, optionally after an idle gap.
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
            if (gap > 0) begin
                @(negedge i_clk);
                s_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        word                                         = '0;
        word[lfg_pkg::S_CH_LO  +: lfg_pkg::CHAN_W]   = ch;
        word[lfg_pkg::S_TGT_LO +: lfg_pkg::TGT_W]    = tgt;
        word[lfg_pkg::S_DUR_LO +: lfg_pkg::TIME_W]   = dur;
        word[lfg_pkg::S_NOW_LO +: lfg_pkg::TIME_W]   = now;
        @(negedge i_clk);
        s_tdata <= word;
        s_tuser <= op;
        s_valid <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!s_ready);
        track_command(op, ch, tgt, dur, now);
    endtask

    task automatic send_fade(input int ch, input int tgt, input logic [lfg_pkg::TIME_W-1:0] dur,
                             input logic [lfg_pkg::TIME_W-1:0] now);
        send_item(lfg_pkg::OP_FADE, lfg_pkg::CHAN_W'(ch), lfg_pkg::TGT_W'(tgt), dur, now);
    endtask

    task automatic send_refresh(input logic [lfg_pkg::TIME_W-1:0] now);
        send_item(lfg_pkg::OP_REFRESH, lfg_pkg::CHAN_W'($urandom()), lfg_pkg::TGT_W'($urandom()),
                  $urandom(), now);
    endtask

    // Hold the input idle until every queued result has been taken.
    task automatic wait_drained();
        @(negedge i_clk);
        s_valid <= 1'b0;
        burst_left = 0;
        wait (pwm_expected_q.size() == 0);
    endtask

    task automatic test_reset_state();
        send_refresh(32'd0);
    endtask

    // Zero-length fades, including targets above the 12-bit range.
    task automatic test_immediate_set();
        send_fade(0, 0, 32'd0, 32'd10);
        send_fade(1, 1, 32'd0, 32'd10);
        send_fade(2, lfg_pkg::MAX_LEVEL, 32'd0, 32'd10);
        send_fade(3, lfg_pkg::MAX_LEVEL + 1, 32'd0, 32'd10);
        send_fade(4, 16'hFFFF, 32'd0, 32'd10);
        send_fade(5, 16'h8000, 32'd0, 32'd10);
        send_refresh(32'd20);
    endtask

    task automatic test_ignored_channels();
        send_fade(lfg_pkg::CHANNELS, lfg_pkg::MAX_LEVEL, 32'd0, 32'd30);
        send_fade(63, 2000, 32'd0, 32'd30);
        send_refresh(32'd40);
    endtask

    // Fades up, down and uneven, a retarget mid-fade, then completion.
    task automatic test_fade_progress();
        send_fade(0, lfg_pkg::MAX_LEVEL, 32'd1000, 32'd1000);
        send_fade(2, 0, 32'hFFFF_FFFF, 32'd1000);
        send_fade(6, 3000, 32'd7, 32'd1000);
        send_refresh(32'd1500);
        send_fade(0, 100, 32'd333, 32'd1600);
        send_refresh(32'd1700);
        send_refresh(32'd3000);
    endtask

    // Fade that straddles the wrap of the millisecond counter.
    task automatic test_time_wrap();
        send_fade(7, 2500, 32'h200, 32'hFFFF_FF00);
        send_refresh(32'h0000_0050);
        send_refresh(32'h0000_0300);
    endtask

    task automatic test_refresh_fields();
        send_item(lfg_pkg::OP_REFRESH, '1, '1, '1, 32'h0000_0400);
    endtask

    // Mostly well-formed fades on live channels over a drifting clock, with refreshes mixed in.
    task automatic test_random_traffic();
        int                         counted;
        int                         roll;
        logic [lfg_pkg::CHAN_W-1:0] ch;
        logic [lfg_pkg::TGT_W-1:0]  tgt;
        logic [lfg_pkg::TIME_W-1:0] dur;
        logic                       paused;
        counted = 0;
        paused  = 1'b0;
        wall_ms = 32'h0000_0500;
        while (counted < 438) begin
            roll = $urandom_range(0, 99);
            if (roll < 4) begin
                wall_ms = $urandom();
            end else if (roll < 6) begin
                wall_ms -= $urandom_range(1, 500);
            end else begin
                wall_ms += $urandom_range(0, 400);
            end
            if ($urandom_range(0, 99) < 30) begin
                send_refresh(wall_ms);
            end else begin
                ch  = ($urandom_range(0, 9) == 0)
                    ? lfg_pkg::CHAN_W'($urandom_range(lfg_pkg::CHANNELS, 63))
                    : lfg_pkg::CHAN_W'($urandom_range(0, lfg_pkg::CHANNELS - 1));
                tgt = ($urandom_range(0, 4) == 0)
                    ? lfg_pkg::TGT_W'($urandom())
                    : lfg_pkg::TGT_W'($urandom_range(0, lfg_pkg::MAX_LEVEL));
                case ($urandom_range(0, 9))
                    0:       dur = '0;
                    1, 2:    dur = $urandom();
                    3:       dur = $urandom_range(0, 65535);
                    default: dur = $urandom_range(1, 2000);
                endcase
                send_item(lfg_pkg::OP_FADE, ch, tgt, dur, wall_ms);
            end
            counted++;
            // Let the engine run dry once in the middle of the traffic.
            if (!paused && counted >= 219) begin
                paused = 1'b1;
                wait_drained();
            end
        end
    endtask

    // Receiver: switch at random between back-pressure patterns.
    always @(negedge i_clk) begin
        if (rx_left == 0) begin
            rx_mode <= t_rx_mode'($urandom_range(0, 3));
            rx_left <= $urandom_range(8, 80);
        end else begin
            rx_left <= rx_left - 1;
        end
        case (rx_mode)
            RX_OPEN:   m_ready <= 1'b1;
            RX_COIN:   m_ready <= 1'($urandom_range(0, 1));
            RX_SPARSE: m_ready <= ($urandom_range(0, 3) == 0);
            default:   m_ready <= (rx_left % 16 == 0);
        endcase
    end

    // Compare every accepted result with the oldest queued expectation.
    always @(posedge i_clk) begin : result_check
        t_pwm_result want;
        t_pwm_result got;
        if (i_rst_n && m_valid && m_ready) begin
            got.ch   = m_tdata[lfg_pkg::M_CH_LO +: lfg_pkg::CHAN_W];
            got.pwm  = m_tdata[lfg_pkg::M_PWM_LO +: lfg_pkg::PWM_W];
            got.last = m_last;
            if (pwm_expected_q.size() == 0) begin
                $display("%0t: unexpected result ch %0d pwm %0d last %0b",
                         $time, got.ch, got.pwm, got.last);
                fail_count++;
            end else begin
                want = pwm_expected_q.pop_front();
                if (got.ch !== want.ch) begin
                    $display("%0t: out_channel expected %0d actual %0d",
                             $time, want.ch, got.ch);
                    fail_count++;
                end
                if (got.pwm !== want.pwm) begin
                    $display("%0t: pwm_value ch %0d expected %0d actual %0d",
                             $time, want.ch, want.pwm, got.pwm);
                    fail_count++;
                end
                if (got.last !== want.last) begin
                    $display("%0t: last ch %0d expected %0b actual %0b",
                             $time, want.ch, want.last, got.last);
                    fail_count++;
                end
            end
        end
    end

    initial begin : run_sequence
        logic [131:0] scale;
        logic [131:0] pw;
        logic [131:0] cand;
        int           y;
        int           i;
        int           k;
        logic         climbing;
        // Gamma table: largest y with y^5 * 4095^6 <= i^11, scanned upward since it never drops.
        scale = 132'd1;
        for (k = 0; k < 6; k++) begin
            scale = scale * 132'(lfg_pkg::MAX_LEVEL);
        end
        y = 0;
        for (i = 0; i < lfg_pkg::ROM_DEPTH; i++) begin
            pw = 132'd1;
            for (k = 0; k < 11; k++) begin
                pw = pw * 132'(i);
            end
            climbing = 1'b1;
            while (climbing && y < lfg_pkg::MAX_LEVEL) begin
                cand = scale;
                for (k = 0; k < 5; k++) begin
                    cand = cand * 132'(y + 1);
                end
                if (cand <= pw) begin
                    y++;
                end else begin
                    climbing = 1'b0;
                end
            end
            gamma_lut[i] = lfg_pkg::LVL_W'(y);
        end
        for (i = 0; i < lfg_pkg::CHANNELS; i++) begin
            chan_level[i]  = '0;
            chan_fading[i] = 1'b0;
            fade_from[i]   = '0;
            fade_to[i]     = '0;
            fade_t0[i]     = '0;
            fade_len[i]    = '0;
        end

        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_state();
        test_immediate_set();
        test_ignored_channels();
        test_fade_progress();
        test_time_wrap();
        test_refresh_fields();
        test_random_traffic();

        // Drain, then keep watching for stray output before the final check.
        wait_drained();
        repeat (400) @(posedge i_clk);
        if (pwm_expected_q.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pwm_expected_q.size());
            fail_count++;
        end
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    // Watchdog: several times the slowest legal run.
    initial begin
        #3_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
